FILE: rtl/srve_pkg.sv
// Shared constants and types for the shadow ray vertex extender.
package srve_pkg;

    localparam int CoordW   = 42;
    localparam int CoefW    = 21;
    localparam int CoefFrac = 19;
    localparam int RowW     = 3 * CoefW;
    localparam int LenW     = 41;
    localparam int LenLoW   = 21;
    localparam int UnitFrac = 30;
    localparam int AccW     = 64;
    localparam int TW       = 46;
    localparam int DiffW    = 47;
    localparam int MagW     = DiffW - 1;
    localparam int MW       = 31;
    localparam int ShiftW   = 4;
    localparam int SqW      = 2 * MW;
    localparam int N2W      = 64;
    localparam int NW       = 32;
    localparam int UW       = 31;
    localparam int DivdW    = MW + UnitFrac + 1;
    localparam int EW       = 42;
    localparam int SumW     = CoordW + 2;

    localparam int XfStages  = 5;
    localparam int NrmStages = 4;
    localparam int SqSteps   = 32;
    localparam int DivSteps  = UW;
    localparam int ExtStages = 3;
    localparam int Latency   = XfStages + NrmStages + SqSteps + 1 + DivSteps + ExtStages;

    localparam longint CoordMax = (64'sd1 <<< (CoordW - 1)) - 64'sd1;
    localparam longint CoordMin = -CoordMax - 64'sd1;

    typedef enum logic [2:0] {
        RegRot0   = 3'd0,
        RegRot1   = 3'd1,
        RegRot2   = 3'd2,
        RegOffX   = 3'd3,
        RegOffY   = 3'd4,
        RegOffZ   = 3'd5,
        RegLength = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][CoordW-1:0] dst;
        logic [2:0]             neg;
        logic [2:0][MW-1:0]     m;
    } t_side;

endpackage

FILE: rtl/srve_xform.sv
// Rotation, translation and difference stages producing the direction vector.
module srve_xform (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [2:0][srve_pkg::CoordW-1:0]        i_src,
    input  logic [2:0][srve_pkg::CoordW-1:0]        i_dst,
    input  logic [2:0][srve_pkg::RowW-1:0]          i_rot,
    input  logic [2:0][srve_pkg::CoordW-1:0]        i_offset,
    output logic                                    o_valid,
    output logic [2:0][srve_pkg::DiffW-1:0]         o_d,
    output logic [2:0][srve_pkg::CoordW-1:0]        o_dst
);

    localparam int LoW = srve_pkg::CoefW;
    localparam int HiW = srve_pkg::CoordW - LoW;

    logic [srve_pkg::XfStages-1:0]                  r_vld;
    logic [2:0][srve_pkg::CoordW-1:0]               r_dst [srve_pkg::XfStages];
    logic signed [srve_pkg::CoefW+HiW-1:0]          r_ph [3][3];
    logic signed [srve_pkg::CoefW+LoW:0]            r_pl [3][3];
    logic signed [srve_pkg::AccW-1:0]               r_prod [3][3];
    logic signed [srve_pkg::AccW-1:0]               r_acc [3];
    logic signed [srve_pkg::TW-1:0]                 r_t [3];
    logic [2:0][srve_pkg::DiffW-1:0]                r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[srve_pkg::XfStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst[0] <= i_dst;
        for (int s = 1; s < srve_pkg::XfStages; s++) begin
            r_dst[s] <= r_dst[s-1];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_ph[r][c] <= $signed(i_rot[r][c*srve_pkg::CoefW +: srve_pkg::CoefW])
                            * $signed(i_src[c][srve_pkg::CoordW-1:LoW]);
                r_pl[r][c] <= $signed(i_rot[r][c*srve_pkg::CoefW +: srve_pkg::CoefW])
                            * $signed({1'b0, i_src[c][LoW-1:0]});
                r_prod[r][c] <= (srve_pkg::AccW'(r_ph[r][c]) <<< LoW)
                              + srve_pkg::AccW'(r_pl[r][c]);
            end
            r_acc[r] <= r_prod[r][0] + r_prod[r][1] + r_prod[r][2]
                      + (srve_pkg::AccW'(1) <<< (srve_pkg::CoefFrac - 1));
            r_t[r] <= srve_pkg::TW'(r_acc[r] >>> srve_pkg::CoefFrac)
                    + srve_pkg::TW'($signed(i_offset[r]));
            r_d[r] <= srve_pkg::DiffW'($signed(r_dst[srve_pkg::XfStages-2][r]))
                    - srve_pkg::DiffW'(r_t[r]);
        end
    end

    assign o_valid = r_vld[srve_pkg::XfStages-1];
    assign o_d     = r_d;
    assign o_dst   = r_dst[srve_pkg::XfStages-1];

endmodule

FILE: rtl/srve_norm.sv
// Magnitude, range reduction and squared length of the direction vector.
module srve_norm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [2:0][srve_pkg::DiffW-1:0]     i_d,
    input  logic [2:0][srve_pkg::CoordW-1:0]    i_dst,
    output logic                                o_valid,
    output logic [srve_pkg::N2W-1:0]            o_n2,
    output srve_pkg::t_side                     o_side
);

    logic [srve_pkg::NrmStages-1:0]             r_vld;
    logic [2:0][srve_pkg::MagW-1:0]             r_mag;
    logic [2:0]                                 r_neg [srve_pkg::NrmStages];
    logic [2:0][srve_pkg::CoordW-1:0]           r_dst [srve_pkg::NrmStages];
    logic [2:0][srve_pkg::MW-1:0]               r_m [3];
    logic [srve_pkg::SqW-1:0]                   r_sq [3];
    logic [srve_pkg::N2W-1:0]                   r_n2;
    logic [srve_pkg::MagW-1:0]                  w_or;
    logic [srve_pkg::ShiftW-1:0]                w_k;

    always_comb begin
        w_or = r_mag[0] | r_mag[1] | r_mag[2];
        w_k  = '0;
        for (int i = 0; i < srve_pkg::MagW - srve_pkg::MW; i++) begin
            if (w_or[srve_pkg::MW + i]) begin
                w_k = srve_pkg::ShiftW'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[srve_pkg::NrmStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst[0] <= i_dst;
        for (int s = 1; s < srve_pkg::NrmStages; s++) begin
            r_dst[s] <= r_dst[s-1];
            r_neg[s] <= r_neg[s-1];
        end
        r_m[1] <= r_m[0];
        r_m[2] <= r_m[1];
        for (int r = 0; r < 3; r++) begin
            r_neg[0][r] <= i_d[r][srve_pkg::DiffW-1];
            r_mag[r] <= i_d[r][srve_pkg::DiffW-1]
                      ? srve_pkg::MagW'(-$signed(i_d[r])) : srve_pkg::MagW'(i_d[r]);
            r_m[0][r] <= srve_pkg::MW'(r_mag[r] >> w_k);
            r_sq[r] <= srve_pkg::SqW'(r_m[0][r]) * srve_pkg::SqW'(r_m[0][r]);
        end
        r_n2 <= srve_pkg::N2W'(r_sq[0]) + srve_pkg::N2W'(r_sq[1])
              + srve_pkg::N2W'(r_sq[2]);
    end

    assign o_valid    = r_vld[srve_pkg::NrmStages-1];
    assign o_n2       = r_n2;
    assign o_side.dst = r_dst[srve_pkg::NrmStages-1];
    assign o_side.neg = r_neg[srve_pkg::NrmStages-1];
    assign o_side.m   = r_m[2];

endmodule

FILE: rtl/srve_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module srve_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [srve_pkg::N2W-1:0]        i_n2,
    input  srve_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic [srve_pkg::NW-1:0]         o_n,
    output srve_pkg::t_side                 o_side
);

    logic                           r_vld  [srve_pkg::SqSteps];
    logic [srve_pkg::N2W-1:0]       r_rem  [srve_pkg::SqSteps];
    logic [srve_pkg::N2W-1:0]       r_res  [srve_pkg::SqSteps];
    srve_pkg::t_side                r_side [srve_pkg::SqSteps];

    for (genvar s = 0; s < srve_pkg::SqSteps; s++) begin : g_step
        localparam logic [srve_pkg::N2W-1:0] Bit =
            srve_pkg::N2W'(1) << (srve_pkg::N2W - 2 - 2 * s);
        logic                       w_vld;
        logic [srve_pkg::N2W-1:0]   w_rem;
        logic [srve_pkg::N2W-1:0]   w_res;
        logic [srve_pkg::N2W-1:0]   w_trial;
        srve_pkg::t_side            w_side;

        if (s == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_rem  = i_n2;
            assign w_res  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_res  = r_res[s-1];
            assign w_side = r_side[s-1];
        end

        assign w_trial = w_res + Bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[s] <= w_side;
            if (w_rem >= w_trial) begin
                r_rem[s] <= w_rem - w_trial;
                r_res[s] <= (w_res >> 1) + Bit;
            end else begin
                r_rem[s] <= w_rem;
                r_res[s] <= w_res >> 1;
            end
        end
    end

    assign o_valid = r_vld[srve_pkg::SqSteps-1];
    assign o_n     = srve_pkg::NW'(r_res[srve_pkg::SqSteps-1]);
    assign o_side  = r_side[srve_pkg::SqSteps-1];

endmodule

FILE: rtl/srve_div.sv
// Pipelined restoring divider that forms the three unit direction components.
module srve_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [srve_pkg::NW-1:0]         i_n,
    input  srve_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic                            o_nz,
    output logic [2:0][srve_pkg::UW-1:0]    o_u,
    output srve_pkg::t_side                 o_side
);

    localparam int LowW = srve_pkg::UW;
    localparam int RemW = srve_pkg::NW;

    logic                           r_pvld;
    logic [srve_pkg::NW-1:0]        r_pn;
    logic [2:0][RemW-1:0]           r_prem;
    logic [2:0][LowW-1:0]           r_plow;
    srve_pkg::t_side                r_pside;

    logic                           r_vld  [srve_pkg::DivSteps];
    logic [srve_pkg::NW-1:0]        r_n    [srve_pkg::DivSteps];
    logic [2:0][RemW-1:0]           r_rem  [srve_pkg::DivSteps];
    logic [2:0][LowW-1:0]           r_low  [srve_pkg::DivSteps];
    logic [2:0][srve_pkg::UW-1:0]   r_q    [srve_pkg::DivSteps];
    srve_pkg::t_side                r_side [srve_pkg::DivSteps];

    logic [2:0][srve_pkg::DivdW-1:0] w_divd;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_divd[l] = (srve_pkg::DivdW'(i_side.m[l]) << srve_pkg::UnitFrac)
                      + srve_pkg::DivdW'(i_n >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pn    <= i_n;
        r_pside <= i_side;
        for (int l = 0; l < 3; l++) begin
            r_prem[l] <= RemW'(w_divd[l][srve_pkg::DivdW-1:LowW]);
            r_plow[l] <= w_divd[l][LowW-1:0];
        end
    end

    for (genvar s = 0; s < srve_pkg::DivSteps; s++) begin : g_step
        logic                           w_vld;
        logic [srve_pkg::NW-1:0]        w_n;
        logic [2:0][RemW-1:0]           w_rem;
        logic [2:0][LowW-1:0]           w_low;
        logic [2:0][srve_pkg::UW-1:0]   w_q;
        srve_pkg::t_side                w_side;

        if (s == 0) begin : g_first
            assign w_vld  = r_pvld;
            assign w_n    = r_pn;
            assign w_rem  = r_prem;
            assign w_low  = r_plow;
            assign w_q    = '0;
            assign w_side = r_pside;
        end else begin : g_next
            assign w_vld  = r_vld[s-1];
            assign w_n    = r_n[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_low  = r_low[s-1];
            assign w_q    = r_q[s-1];
            assign w_side = r_side[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            logic [RemW:0] v_t;
            r_n[s]    <= w_n;
            r_side[s] <= w_side;
            for (int l = 0; l < 3; l++) begin
                v_t = {w_rem[l], w_low[l][LowW-1]};
                r_low[s][l] <= w_low[l] << 1;
                if (v_t >= {1'b0, w_n}) begin
                    r_rem[s][l] <= RemW'(v_t - {1'b0, w_n});
                    r_q[s][l]   <= {w_q[l][srve_pkg::UW-2:0], 1'b1};
                end else begin
                    r_rem[s][l] <= RemW'(v_t);
                    r_q[s][l]   <= {w_q[l][srve_pkg::UW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[srve_pkg::DivSteps-1];
    assign o_nz    = (r_n[srve_pkg::DivSteps-1] != '0);
    assign o_u     = r_q[srve_pkg::DivSteps-1];
    assign o_side  = r_side[srve_pkg::DivSteps-1];

`ifndef SYNTHESIS
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_nz) |->
            (o_u[0] <= (srve_pkg::UW'(1) << srve_pkg::UnitFrac))
            && (o_u[1] <= (srve_pkg::UW'(1) << srve_pkg::UnitFrac))
            && (o_u[2] <= (srve_pkg::UW'(1) << srve_pkg::UnitFrac)))
        else $error("unit direction component above one");
`endif

endmodule

FILE: rtl/srve_extend.sv
// Length scaling, end vertex addition and saturation stages.
module srve_extend (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_nz,
    input  logic [2:0][srve_pkg::UW-1:0]        i_u,
    input  srve_pkg::t_side                     i_side,
    input  logic [srve_pkg::LenW-1:0]           i_len,
    output logic                                o_valid,
    output logic [2:0][srve_pkg::CoordW-1:0]    o_start,
    output logic [2:0][srve_pkg::CoordW-1:0]    o_end
);

    localparam int HiLenW = srve_pkg::LenW - srve_pkg::LenLoW;
    localparam int AW     = srve_pkg::UW + HiLenW;
    localparam int BW     = srve_pkg::UW + srve_pkg::LenLoW;
    localparam int PW     = srve_pkg::UW + srve_pkg::LenW;

    logic [srve_pkg::ExtStages-1:0]         r_vld;
    logic                                   r_nz [2];
    logic [2:0]                             r_neg [2];
    logic [2:0][srve_pkg::CoordW-1:0]       r_dst [2];
    logic [AW-1:0]                          r_a [3];
    logic [BW-1:0]                          r_b [3];
    logic [srve_pkg::EW-1:0]                r_e [3];
    logic [2:0][srve_pkg::CoordW-1:0]       r_start;
    logic [2:0][srve_pkg::CoordW-1:0]       r_end;
    logic signed [srve_pkg::SumW-1:0]       w_sum [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r_neg[1][r]) begin
                w_sum[r] = srve_pkg::SumW'($signed(r_dst[1][r]))
                         - $signed({2'b00, r_e[r]});
            end else begin
                w_sum[r] = srve_pkg::SumW'($signed(r_dst[1][r]))
                         + $signed({2'b00, r_e[r]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[srve_pkg::ExtStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_nz[0]  <= i_nz;
        r_nz[1]  <= r_nz[0];
        r_neg[0] <= i_side.neg;
        r_neg[1] <= r_neg[0];
        r_dst[0] <= i_side.dst;
        r_dst[1] <= r_dst[0];
        r_start  <= r_dst[1];
        for (int r = 0; r < 3; r++) begin
            r_a[r] <= AW'(i_u[r]) * AW'(i_len[srve_pkg::LenW-1:srve_pkg::LenLoW]);
            r_b[r] <= BW'(i_u[r]) * BW'(i_len[srve_pkg::LenLoW-1:0]);
            r_e[r] <= srve_pkg::EW'(((PW'(r_a[r]) << srve_pkg::LenLoW) + PW'(r_b[r])
                    + (PW'(1) << (srve_pkg::UnitFrac - 1))) >> srve_pkg::UnitFrac);
            if (!r_nz[1]) begin
                r_end[r] <= r_dst[1][r];
            end else if (w_sum[r] > srve_pkg::SumW'(srve_pkg::CoordMax)) begin
                r_end[r] <= srve_pkg::CoordW'(srve_pkg::CoordMax);
            end else if (w_sum[r] < srve_pkg::SumW'(srve_pkg::CoordMin)) begin
                r_end[r] <= srve_pkg::CoordW'(srve_pkg::CoordMin);
            end else begin
                r_end[r] <= srve_pkg::CoordW'(w_sum[r]);
            end
        end
    end

    assign o_valid = r_vld[srve_pkg::ExtStages-1];
    assign o_start = r_start;
    assign o_end   = r_end;

`ifndef SYNTHESIS
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[srve_pkg::ExtStages-2] && !r_nz[1]) |=> (o_end == o_start))
        else $error("zero direction must leave the end vertex on the start vertex");
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && ($past(i_len) == '0)) |=>
            (r_e[0] == '0) && (r_e[1] == '0) && (r_e[2] == '0))
        else $error("zero length must give zero extension");
`endif

endmodule

FILE: rtl/shadow_ray_vertex_extend_top.sv
// Top level of the shadow ray vertex extender: configuration registers and stage chain.
//
// One point pair is taken in every clock cycle in which start is high, and its start and
// end vertices appear on the outputs for one cycle, marked by o_done. The pipeline runs
// through the matrix multiply and range reduction stages, the 32-stage square root pipeline,
// the divider that normalizes the direction and the length scaling stages.
// busy stays low since the pipeline never stalls, and the receiver must take each beat
// in the cycle it is shown.
module shadow_ray_vertex_extend_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_wr_en,
    input  logic [2:0]                      i_cfg_addr,
    input  logic [srve_pkg::RowW-1:0]       i_cfg_wdata,
    input  logic [srve_pkg::CoordW-1:0]     i_src_x,
    input  logic [srve_pkg::CoordW-1:0]     i_src_y,
    input  logic [srve_pkg::CoordW-1:0]     i_src_z,
    input  logic [srve_pkg::CoordW-1:0]     i_dst_x,
    input  logic [srve_pkg::CoordW-1:0]     i_dst_y,
    input  logic [srve_pkg::CoordW-1:0]     i_dst_z,
    output logic                            o_done,
    output logic [srve_pkg::CoordW-1:0]     o_start_x,
    output logic [srve_pkg::CoordW-1:0]     o_start_y,
    output logic [srve_pkg::CoordW-1:0]     o_start_z,
    output logic [srve_pkg::CoordW-1:0]     o_end_x,
    output logic [srve_pkg::CoordW-1:0]     o_end_y,
    output logic [srve_pkg::CoordW-1:0]     o_end_z
);

    logic [2:0][srve_pkg::RowW-1:0]         r_rot;
    logic [2:0][srve_pkg::CoordW-1:0]       r_offset;
    logic [srve_pkg::LenW-1:0]              r_len;

    logic                                   w_in_vld;
    logic                                   w_xf_vld;
    logic [2:0][srve_pkg::DiffW-1:0]        w_d;
    logic [2:0][srve_pkg::CoordW-1:0]       w_xf_dst;
    logic                                   w_nrm_vld;
    logic [srve_pkg::N2W-1:0]               w_n2;
    srve_pkg::t_side                        w_nrm_side;
    logic                                   w_sq_vld;
    logic [srve_pkg::NW-1:0]                w_n;
    srve_pkg::t_side                        w_sq_side;
    logic                                   w_div_vld;
    logic                                   w_nz;
    logic [2:0][srve_pkg::UW-1:0]           w_u;
    srve_pkg::t_side                        w_div_side;
    logic [2:0][srve_pkg::CoordW-1:0]       w_start;
    logic [2:0][srve_pkg::CoordW-1:0]       w_end;

    assign busy     = 1'b0;
    assign w_in_vld = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot    <= '0;
            r_offset <= '0;
            r_len    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (srve_pkg::t_reg_idx'(i_cfg_addr))
                srve_pkg::RegRot0:   r_rot[0]    <= i_cfg_wdata;
                srve_pkg::RegRot1:   r_rot[1]    <= i_cfg_wdata;
                srve_pkg::RegRot2:   r_rot[2]    <= i_cfg_wdata;
                srve_pkg::RegOffX:   r_offset[0] <= i_cfg_wdata[srve_pkg::CoordW-1:0];
                srve_pkg::RegOffY:   r_offset[1] <= i_cfg_wdata[srve_pkg::CoordW-1:0];
                srve_pkg::RegOffZ:   r_offset[2] <= i_cfg_wdata[srve_pkg::CoordW-1:0];
                srve_pkg::RegLength: r_len       <= i_cfg_wdata[srve_pkg::LenW-1:0];
                default: ;
            endcase
        end
    end

    srve_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_vld),
        .i_src    ({i_src_z, i_src_y, i_src_x}),
        .i_dst    ({i_dst_z, i_dst_y, i_dst_x}),
        .i_rot    (r_rot),
        .i_offset (r_offset),
        .o_valid  (w_xf_vld),
        .o_d      (w_d),
        .o_dst    (w_xf_dst)
    );

    srve_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xf_vld),
        .i_d     (w_d),
        .i_dst   (w_xf_dst),
        .o_valid (w_nrm_vld),
        .o_n2    (w_n2),
        .o_side  (w_nrm_side)
    );

    srve_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_nrm_vld),
        .i_n2    (w_n2),
        .i_side  (w_nrm_side),
        .o_valid (w_sq_vld),
        .o_n     (w_n),
        .o_side  (w_sq_side)
    );

    srve_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_vld),
        .i_n     (w_n),
        .i_side  (w_sq_side),
        .o_valid (w_div_vld),
        .o_nz    (w_nz),
        .o_u     (w_u),
        .o_side  (w_div_side)
    );

    srve_extend u_extend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_vld),
        .i_nz    (w_nz),
        .i_u     (w_u),
        .i_side  (w_div_side),
        .i_len   (r_len),
        .o_valid (o_done),
        .o_start (w_start),
        .o_end   (w_end)
    );

    assign o_start_x = w_start[0];
    assign o_start_y = w_start[1];
    assign o_start_z = w_start[2];
    assign o_end_x   = w_end[0];
    assign o_end_y   = w_end[1];
    assign o_end_z   = w_end[2];

`ifndef SYNTHESIS
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_in_vld, srve_pkg::Latency))
        else $error("result beat without a matching accepted item");
    a_start_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_start_x == $past(i_dst_x, srve_pkg::Latency)))
        else $error("start vertex does not match the accepted destination");
`endif

endmodule
